[sv/psa_pkg.sv]
package psa_pkg;

	localparam int KEY_W    = 64;
	localparam int CNT_W    = 7;
	localparam int KIND_W   = 2;
	localparam int STATUS_W = 3;

	localparam int DEF_SESSION_SLOTS  = 64;
	localparam int DEF_IDENTITY_SLOTS = 64;

	localparam logic [CNT_W-1:0] LIMIT_RESET = 7'd1;

	localparam logic [KIND_W-1:0] KIND_ADMIT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_OTHER    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_LIMIT    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SES_SCAN,
		S_IDN_SCAN,
		S_ADMIT,
		S_REL_RD,
		S_REL_WR,
		S_FINISH
	} state_t;

endpackage

[sv/psa_ram.sv]
module psa_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[sv/per_identity_session_admission_core.sv]
// Session admission with a per-identity session limit.
// Request channel: start with kind, session_number and identity_key is taken
// at a rising edge where start is high and busy is low. busy stays high until
// the result has been produced. kind selects admit, release or count query.
// Result channel: done is high for exactly one cycle with accepted, status,
// identity_active and total_active; the receiver has no way to stall it.
// Configuration: cfg_wr_en writes cfg_wr_data into the per-identity limit at
// any edge; write it only while busy is low and no result is pending.
// Each request walks its tables through one shared 64-bit comparator, one
// entry per cycle from registered-read memories:
//   admit   the session table and then the identity table
//   release the session table, then reads the identity slot and writes back;
//           an unknown session ends at the read with not-found
//   query   the identity table
//   kind 3  no table; it finishes as invalid
// One request is in flight at a time; the next may start in the done cycle.
// Reset: both tables are wiped by a clearing pass over every entry, with
// busy high meanwhile.
// The limit resets to one and the session total to zero.
module per_identity_session_admission_core
	import psa_pkg::*;
#(
	parameter int SESSION_SLOTS  = DEF_SESSION_SLOTS,
	parameter int IDENTITY_SLOTS = DEF_IDENTITY_SLOTS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [KIND_W-1:0]   kind,
	input  logic [KEY_W-1:0]    session_number,
	input  logic [KEY_W-1:0]    identity_key,
	input  logic                cfg_wr_en,
	input  logic [CNT_W-1:0]    cfg_wr_data,
	output logic                done,
	output logic                accepted,
	output logic [STATUS_W-1:0] status,
	output logic [CNT_W-1:0]    identity_active,
	output logic [CNT_W-1:0]    total_active
);

	localparam int SAW   = $clog2(SESSION_SLOTS);
	localparam int IAW   = $clog2(IDENTITY_SLOTS);
	localparam int MAXS  = (SESSION_SLOTS > IDENTITY_SLOTS) ? SESSION_SLOTS : IDENTITY_SLOTS;
	localparam int CW    = $clog2(MAXS + 1);
	localparam int TW    = $clog2(SESSION_SLOTS + 1);

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] id;
		logic [IAW-1:0]   slot;
	} ses_word_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [KEY_W-1:0] key;
	} idn_word_t;

	localparam int SES_W = $bits(ses_word_t);
	localparam int IDN_W = $bits(idn_word_t);

	state_t state_q, state_d;

	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       idx_s1;
	logic                vld_s1;

	logic [KIND_W-1:0]   kind_q;
	logic [KEY_W-1:0]    sid_q;
	logic [KEY_W-1:0]    key_q;
	logic [CNT_W-1:0]    limit_q;
	logic [TW-1:0]       total_q;

	logic                ses_hit_q;
	logic [SAW-1:0]      ses_idx_q;
	logic [IAW-1:0]      ses_slot_q;
	logic                free_s_ok_q;
	logic [SAW-1:0]      free_s_q;
	logic                idn_hit_q;
	logic [IAW-1:0]      idn_idx_q;
	logic [CNT_W-1:0]    idn_cnt_q;
	logic                free_k_ok_q;
	logic [IAW-1:0]      free_k_q;

	logic                done_q;
	logic                acc_q;
	logic [STATUS_W-1:0] st_q;
	logic [CNT_W-1:0]    act_q;

	logic                ses_we;
	logic [SAW-1:0]      ses_waddr;
	ses_word_t           ses_wdata;
	logic [SES_W-1:0]    ses_rdata;
	ses_word_t           ses_rd;
	logic                idn_we;
	logic [IAW-1:0]      idn_waddr;
	idn_word_t           idn_wdata;
	logic [IAW-1:0]      idn_raddr;
	logic [IDN_W-1:0]    idn_rdata;
	idn_word_t           idn_rd;

	logic [KEY_W-1:0]    cmp_a;
	logic [KEY_W-1:0]    cmp_b;
	logic                cmp_eq;
	logic                ses_match;
	logic                idn_match;

	logic                res_fire;
	logic                res_acc;
	logic [STATUS_W-1:0] res_st;
	logic [CNT_W-1:0]    res_act;
	logic                tot_inc;
	logic                tot_dec;

	logic [CNT_W-1:0]    cnt_now;
	logic                admit_invalid;
	logic [IAW-1:0]      admit_k;
	logic [CNT_W-1:0]    rel_cnt;
	logic [TW+CNT_W-1:0] tot_ext;

	psa_ram #(.W(SES_W), .DEPTH(SESSION_SLOTS)) u_ses_ram (
		.clk   (clk),
		.we    (ses_we),
		.waddr (ses_waddr),
		.wdata (ses_wdata),
		.raddr (idx_q[SAW-1:0]),
		.rdata (ses_rdata)
	);

	psa_ram #(.W(IDN_W), .DEPTH(IDENTITY_SLOTS)) u_idn_ram (
		.clk   (clk),
		.we    (idn_we),
		.waddr (idn_waddr),
		.wdata (idn_wdata),
		.raddr (idn_raddr),
		.rdata (idn_rdata)
	);

	assign ses_rd = ses_word_t'(ses_rdata);
	assign idn_rd = idn_word_t'(idn_rdata);

	// One comparator serves both table walks.
	assign cmp_a     = (state_q == S_SES_SCAN) ? ses_rd.id : idn_rd.key;
	assign cmp_b     = (state_q == S_SES_SCAN) ? sid_q : key_q;
	assign cmp_eq    = (cmp_a == cmp_b);
	assign ses_match = vld_s1 && ses_rd.valid && cmp_eq;
	assign idn_match = vld_s1 && (idn_rd.count != '0) && cmp_eq;

	assign cnt_now       = idn_hit_q ? idn_cnt_q : '0;
	assign admit_invalid = (sid_q == '0) || (key_q == '0) || (limit_q == '0);
	assign admit_k       = idn_hit_q ? idn_idx_q : free_k_q;
	assign rel_cnt       = (idn_rd.count <= CNT_W'(1)) ? '0 : idn_rd.count - CNT_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ses_we    = 1'b0;
		ses_waddr = idx_q[SAW-1:0];
		ses_wdata = '0;
		idn_we    = 1'b0;
		idn_waddr = idx_q[IAW-1:0];
		idn_wdata = '0;
		idn_raddr = idx_q[IAW-1:0];
		res_fire  = 1'b0;
		res_acc   = 1'b0;
		res_st    = ST_OK;
		res_act   = '0;
		tot_inc   = 1'b0;
		tot_dec   = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ses_we = (idx_q < CW'(SESSION_SLOTS));
				idn_we = (idx_q < CW'(IDENTITY_SLOTS));
				if (idx_q == CW'(MAXS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					unique case (kind) inside
						KIND_ADMIT, KIND_RELEASE: state_d = S_SES_SCAN;
						KIND_QUERY:               state_d = S_IDN_SCAN;
						default:                  state_d = S_FINISH;
					endcase
				end
			end
			S_SES_SCAN: begin
				if (idx_q == CW'(SESSION_SLOTS)) begin
					state_d = (kind_q == KIND_RELEASE) ? S_REL_RD : S_IDN_SCAN;
				end
			end
			S_IDN_SCAN: begin
				if (idx_q == CW'(IDENTITY_SLOTS)) begin
					state_d = (kind_q == KIND_ADMIT) ? S_ADMIT : S_FINISH;
				end
			end
			S_ADMIT: begin
				state_d  = S_IDLE;
				res_fire = 1'b1;
				res_act  = cnt_now;
				if (admit_invalid) begin
					res_st = ST_INVALID;
				end else if (ses_hit_q) begin
					if (idn_hit_q && (idn_idx_q == ses_slot_q)) begin
						res_acc = 1'b1;
					end else begin
						res_st = ST_OTHER;
					end
				end else if (cnt_now >= limit_q) begin
					res_st = ST_LIMIT;
				end else if (!free_s_ok_q || (!idn_hit_q && !free_k_ok_q)) begin
					res_st = ST_FULL;
				end else begin
					// bind the session and bump the key's count
					res_acc         = 1'b1;
					res_act         = cnt_now + CNT_W'(1);
					tot_inc         = 1'b1;
					idn_we          = 1'b1;
					idn_waddr       = admit_k;
					idn_wdata.count = cnt_now + CNT_W'(1);
					idn_wdata.key   = key_q;
					ses_we          = 1'b1;
					ses_waddr       = free_s_q;
					ses_wdata.valid = 1'b1;
					ses_wdata.id    = sid_q;
					ses_wdata.slot  = admit_k;
				end
			end
			S_REL_RD: begin
				idn_raddr = ses_slot_q;
				if (ses_hit_q) begin
					state_d = S_REL_WR;
				end else begin
					state_d  = S_IDLE;
					res_fire = 1'b1;
					res_st   = ST_NOTFOUND;
				end
			end
			S_REL_WR: begin
				state_d   = S_IDLE;
				res_fire  = 1'b1;
				res_acc   = 1'b1;
				tot_dec   = (total_q != '0);
				ses_we    = 1'b1;
				ses_waddr = ses_idx_q;
				if (idn_rd.count != '0) begin
					res_act         = rel_cnt;
					idn_we          = 1'b1;
					idn_waddr       = ses_slot_q;
					idn_wdata.count = rel_cnt;
					idn_wdata.key   = idn_rd.key;
				end
			end
			S_FINISH: begin
				state_d  = S_IDLE;
				res_fire = 1'b1;
				if (kind_q == KIND_QUERY) begin
					res_act = cnt_now;
				end else begin
					res_st = ST_INVALID;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (state_d != state_q) begin
				idx_q <= '0;
			end else if (state_q == S_CLEAR || state_q == S_SES_SCAN
					|| state_q == S_IDN_SCAN) begin
				idx_q <= idx_q + CW'(1);
			end
			vld_s1 <= ((state_q == S_SES_SCAN) && (idx_q < CW'(SESSION_SLOTS)))
				|| ((state_q == S_IDN_SCAN) && (idx_q < CW'(IDENTITY_SLOTS)));
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ses_hit_q   <= 1'b0;
			free_s_ok_q <= 1'b0;
			idn_hit_q   <= 1'b0;
			free_k_ok_q <= 1'b0;
		end else if (state_q == S_IDLE && start) begin
			ses_hit_q   <= 1'b0;
			free_s_ok_q <= 1'b0;
			idn_hit_q   <= 1'b0;
			free_k_ok_q <= 1'b0;
		end else if (state_q == S_SES_SCAN && vld_s1) begin
			if (ses_match) begin
				ses_hit_q <= 1'b1;
			end
			if (!ses_rd.valid) begin
				free_s_ok_q <= 1'b1;
			end
		end else if (state_q == S_IDN_SCAN && vld_s1) begin
			if (idn_match) begin
				idn_hit_q <= 1'b1;
			end
			if (idn_rd.count == '0) begin
				free_k_ok_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			kind_q <= kind;
			sid_q  <= session_number;
			key_q  <= identity_key;
		end
		if (state_q == S_SES_SCAN && ses_match) begin
			ses_idx_q  <= idx_s1[SAW-1:0];
			ses_slot_q <= ses_rd.slot;
		end
		// keep the first free session slot only
		if (state_q == S_SES_SCAN && vld_s1 && !ses_rd.valid && !free_s_ok_q) begin
			free_s_q <= idx_s1[SAW-1:0];
		end
		if (state_q == S_IDN_SCAN && idn_match) begin
			idn_idx_q <= idx_s1[IAW-1:0];
			idn_cnt_q <= idn_rd.count;
		end
		if (state_q == S_IDN_SCAN && vld_s1 && (idn_rd.count == '0) && !free_k_ok_q) begin
			free_k_q <= idx_s1[IAW-1:0];
		end
		if (res_fire) begin
			acc_q <= res_acc;
			st_q  <= res_st;
			act_q <= res_act;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			total_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			if (tot_inc) begin
				total_q <= total_q + TW'(1);
			end else if (tot_dec) begin
				total_q <= total_q - TW'(1);
			end
			done_q <= res_fire;
		end
	end

	assign tot_ext         = (TW + CNT_W)'(total_q);
	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign accepted        = acc_q;
	assign status          = st_q;
	assign identity_active = act_q;
	assign total_active    = tot_ext[CNT_W-1:0];

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request taken but block not busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a request in flight");

	a_acc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && accepted |-> status == ST_OK)
		else $error("accepted result with non-ok status");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(SESSION_SLOTS))
		else $error("session total exceeds table size");

	a_single_writer: assert property (@(posedge clk) disable iff (!arst_n)
		tot_inc |-> ses_we && idn_we && !tot_dec)
		else $error("session bound without both table writes");

endmodule
